// ===== hw/rtl/plc_pkg.sv =====
// Shared types, constants and floating-point helpers for the partial likelihood combine unit.
package plc_pkg;

    localparam int NUM_STATES  = 4;
    localparam int MAT_ENTRIES = NUM_STATES * NUM_STATES;
    localparam int STORE_DEPTH = 2 * MAT_ENTRIES;
    localparam int IDX_W       = 5;
    localparam int FP_W        = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int MUL_LAT     = 6;
    localparam int ADD_LAT     = 6;
    localparam int S_TDATA_W   = 584;
    localparam int M_TDATA_W   = NUM_STATES * FP_W;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [10:0] FP_EXP_ALL_ONES = 11'h7FF;
    localparam logic [63:0] FP_QUIET_BIT    = 64'h0008_0000_0000_0000;
    localparam logic [63:0] FP_DEFAULT_NAN  = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] FP_NEG_ZERO     = 64'h8000_0000_0000_0000;

    typedef logic [FP_W-1:0] fp_t;

    typedef struct packed {
        logic                         command;
        logic [IDX_W-1:0]             entry_index;
        fp_t                          entry_value;
        logic [NUM_STATES-1:0][FP_W-1:0] vec_a;
        logic [NUM_STATES-1:0][FP_W-1:0] vec_b;
        logic                         last;
    } plc_item_t;

    function automatic logic fp_is_nan(input fp_t x);
        return (x[62:52] == FP_EXP_ALL_ONES) && (x[51:0] != 52'd0);
    endfunction

    function automatic logic fp_is_inf(input fp_t x);
        return (x[62:52] == FP_EXP_ALL_ONES) && (x[51:0] == 52'd0);
    endfunction

    function automatic logic fp_is_zero(input fp_t x);
        return x[62:0] == 63'd0;
    endfunction

    // Position of the highest set bit, zero when no bit is set.
    function automatic logic [5:0] msb_pos(input logic [63:0] x);
        logic [5:0] pos;
        pos = 6'd0;
        for (int k = 0; k < 64; k++) begin
            if (x[k]) begin
                pos = 6'(k);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hw/rtl/partial_likelihood_combine_unit.sv =====
// Top level of the four-state partial likelihood combine unit.
// A site word passes the input stage, queue, multipliers, adder chain and final multipliers.
// Throughput: one word per cycle, loads and sites alike; the fully pipelined multiply and add
// units set this figure, and an output stall freezes the whole datapath.
// Reset clears the input stage, queue and valid pipeline; the matrix store keeps no reset value.
module partial_likelihood_combine_unit #(
    parameter int QUEUE_DEPTH = plc_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index, entry_value, first_vec_0..3, second_vec_0..3, zero pad
    input  logic [plc_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // partial_0, partial_1, partial_2, partial_3
    output logic [plc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    logic               push, q_ready, q_valid, q_pop;
    plc_pkg::plc_item_t push_item, q_item;

    plc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready)
    );

    plc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    plc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/plc_fp_mul.sv =====
// Six-stage IEEE double multiplier with round to nearest even and full subnormal support.
module plc_fp_mul (
    input  logic             aclk,
    input  logic             en,
    input  plc_pkg::fp_t     a_in,
    input  plc_pkg::fp_t     b_in,
    output plc_pkg::fp_t     y_out
);

    logic               s1_sign_reg, s1_spec_reg;
    plc_pkg::fp_t       s1_spec_val_reg;
    logic [52:0]        s1_ma_reg, s1_mb_reg;
    logic [10:0]        s1_ea_reg, s1_eb_reg;
    logic [5:0]         s1_la_reg, s1_lb_reg;

    logic               s2_sign_reg, s2_spec_reg;
    plc_pkg::fp_t       s2_spec_val_reg;
    logic [52:0]        s2_ma_reg, s2_mb_reg;
    logic signed [12:0] s2_esum_reg;

    logic               s3_sign_reg, s3_spec_reg;
    plc_pkg::fp_t       s3_spec_val_reg;
    logic [53:0]        s3_hh_reg;
    logic [52:0]        s3_hl_reg, s3_lh_reg;
    logic [51:0]        s3_ll_reg;
    logic signed [12:0] s3_esum_reg;

    logic               s4_sign_reg, s4_spec_reg;
    plc_pkg::fp_t       s4_spec_val_reg;
    logic [105:0]       s4_n_reg;
    logic signed [12:0] s4_e_reg;

    logic               s5_sign_reg, s5_spec_reg, s5_ovf_reg, s5_g_reg, s5_st_reg;
    plc_pkg::fp_t       s5_spec_val_reg;
    logic [52:0]        s5_sig_reg;
    logic [10:0]        s5_efield_reg;

    plc_pkg::fp_t       y_reg;

    logic               spec_next;
    plc_pkg::fp_t       spec_val_next;
    logic [52:0]        ma_next, mb_next;
    logic [10:0]        ea_next, eb_next;
    logic [5:0]         la_next, lb_next;
    logic signed [12:0] esum_next;
    logic [53:0]        mid;
    logic [105:0]       prod;
    logic [105:0]       n_next;
    logic signed [12:0] e_next;
    logic signed [12:0] sh_full;
    logic [6:0]         sh;
    logic [211:0]       wide;
    logic               ovf_next, g_next, st_next;
    logic [52:0]        sig_next;
    logic [10:0]        efield_next;
    logic               inc;
    logic [62:0]        mag;
    plc_pkg::fp_t       y_next;

    always_comb begin
        spec_next = 1'b1;
        if (plc_pkg::fp_is_nan(a_in)) begin
            spec_val_next = a_in | plc_pkg::FP_QUIET_BIT;
        end else if (plc_pkg::fp_is_nan(b_in)) begin
            spec_val_next = b_in | plc_pkg::FP_QUIET_BIT;
        end else if ((plc_pkg::fp_is_inf(a_in) && plc_pkg::fp_is_zero(b_in)) ||
                     (plc_pkg::fp_is_zero(a_in) && plc_pkg::fp_is_inf(b_in))) begin
            spec_val_next = plc_pkg::FP_DEFAULT_NAN;
        end else if (plc_pkg::fp_is_inf(a_in) || plc_pkg::fp_is_inf(b_in)) begin
            spec_val_next = {a_in[63] ^ b_in[63], plc_pkg::FP_EXP_ALL_ONES, 52'd0};
        end else if (plc_pkg::fp_is_zero(a_in) || plc_pkg::fp_is_zero(b_in)) begin
            spec_val_next = {a_in[63] ^ b_in[63], 63'd0};
        end else begin
            spec_next     = 1'b0;
            spec_val_next = '0;
        end
        ma_next = {a_in[62:52] != 11'd0, a_in[51:0]};
        mb_next = {b_in[62:52] != 11'd0, b_in[51:0]};
        ea_next = (a_in[62:52] == 11'd0) ? 11'd1 : a_in[62:52];
        eb_next = (b_in[62:52] == 11'd0) ? 11'd1 : b_in[62:52];
        la_next = 6'd52 - plc_pkg::msb_pos({11'd0, ma_next});
        lb_next = 6'd52 - plc_pkg::msb_pos({11'd0, mb_next});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sign_reg     <= a_in[63] ^ b_in[63];
            s1_spec_reg     <= spec_next;
            s1_spec_val_reg <= spec_val_next;
            s1_ma_reg       <= ma_next;
            s1_mb_reg       <= mb_next;
            s1_ea_reg       <= ea_next;
            s1_eb_reg       <= eb_next;
            s1_la_reg       <= la_next;
            s1_lb_reg       <= lb_next;
        end
    end

    assign esum_next = $signed({2'b00, s1_ea_reg}) - $signed({7'd0, s1_la_reg})
                     + $signed({2'b00, s1_eb_reg}) - $signed({7'd0, s1_lb_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_sign_reg     <= s1_sign_reg;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
            s2_ma_reg       <= s1_ma_reg << s1_la_reg;
            s2_mb_reg       <= s1_mb_reg << s1_lb_reg;
            s2_esum_reg     <= esum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_sign_reg     <= s2_sign_reg;
            s3_spec_reg     <= s2_spec_reg;
            s3_spec_val_reg <= s2_spec_val_reg;
            s3_esum_reg     <= s2_esum_reg;
            s3_hh_reg       <= 54'(s2_ma_reg[52:26]) * 54'(s2_mb_reg[52:26]);
            s3_hl_reg       <= 53'(s2_ma_reg[52:26]) * 53'(s2_mb_reg[25:0]);
            s3_lh_reg       <= 53'(s2_ma_reg[25:0]) * 53'(s2_mb_reg[52:26]);
            s3_ll_reg       <= 52'(s2_ma_reg[25:0]) * 52'(s2_mb_reg[25:0]);
        end
    end

    always_comb begin
        mid  = {1'b0, s3_hl_reg} + {1'b0, s3_lh_reg};
        prod = {s3_hh_reg, 52'd0} + ({52'd0, mid} << 26) + {54'd0, s3_ll_reg};
        if (prod[105]) begin
            n_next = prod;
            e_next = s3_esum_reg - 13'sd1022;
        end else begin
            n_next = {prod[104:0], 1'b0};
            e_next = s3_esum_reg - 13'sd1023;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_sign_reg     <= s3_sign_reg;
            s4_spec_reg     <= s3_spec_reg;
            s4_spec_val_reg <= s3_spec_val_reg;
            s4_n_reg        <= n_next;
            s4_e_reg        <= e_next;
        end
    end

    always_comb begin
        ovf_next    = 1'b0;
        sh_full     = 13'sd1 - s4_e_reg;
        sh          = (sh_full > 13'sd107) ? 7'd107 : sh_full[6:0];
        wide        = {s4_n_reg, 106'd0} >> sh;
        sig_next    = s4_n_reg[105:53];
        g_next      = s4_n_reg[52];
        st_next     = |s4_n_reg[51:0];
        efield_next = s4_e_reg[10:0];
        if (s4_e_reg >= 13'sd2047) begin
            ovf_next = 1'b1;
        end else if (s4_e_reg < 13'sd1) begin
            sig_next    = wide[211:159];
            g_next      = wide[158];
            st_next     = |wide[157:0];
            efield_next = 11'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_sign_reg     <= s4_sign_reg;
            s5_spec_reg     <= s4_spec_reg;
            s5_spec_val_reg <= s4_spec_val_reg;
            s5_ovf_reg      <= ovf_next;
            s5_sig_reg      <= sig_next;
            s5_g_reg        <= g_next;
            s5_st_reg       <= st_next;
            s5_efield_reg   <= efield_next;
        end
    end

    always_comb begin
        inc = s5_g_reg & (s5_st_reg | s5_sig_reg[0]);
        mag = {s5_efield_reg, s5_sig_reg[51:0]} + 63'(inc);
        if (s5_spec_reg) begin
            y_next = s5_spec_val_reg;
        end else if (s5_ovf_reg) begin
            y_next = {s5_sign_reg, plc_pkg::FP_EXP_ALL_ONES, 52'd0};
        end else begin
            y_next = {s5_sign_reg, mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;

endmodule

// ===== hw/rtl/plc_fp_add.sv =====
// Six-stage IEEE double adder with round to nearest even and full subnormal support.
module plc_fp_add (
    input  logic         aclk,
    input  logic         en,
    input  plc_pkg::fp_t a_in,
    input  plc_pkg::fp_t b_in,
    output plc_pkg::fp_t y_out
);

    logic         s1_sb_reg, s1_ss_reg, s1_spec_reg;
    plc_pkg::fp_t s1_spec_val_reg;
    logic [52:0]  s1_mb_reg, s1_ms_reg;
    logic [10:0]  s1_e_reg, s1_d_reg;

    logic         s2_sb_reg, s2_ss_reg, s2_spec_reg;
    plc_pkg::fp_t s2_spec_val_reg;
    logic [52:0]  s2_mb_reg;
    logic [55:0]  s2_al_reg;
    logic [10:0]  s2_e_reg;

    logic         s3_sb_reg, s3_zsign_reg, s3_spec_reg;
    plc_pkg::fp_t s3_spec_val_reg;
    logic [56:0]  s3_s_reg;
    logic [10:0]  s3_e_reg;

    logic         s4_sb_reg, s4_zsign_reg, s4_spec_reg, s4_zero_reg;
    plc_pkg::fp_t s4_spec_val_reg;
    logic [55:0]  s4_t_reg;
    logic [11:0]  s4_e_reg;
    logic [5:0]   s4_sh_reg;

    logic         s5_sb_reg, s5_zsign_reg, s5_spec_reg, s5_zero_reg, s5_ovf_reg;
    logic         s5_g_reg, s5_st_reg;
    plc_pkg::fp_t s5_spec_val_reg;
    logic [52:0]  s5_sig_reg;
    logic [10:0]  s5_efield_reg;

    plc_pkg::fp_t y_reg;

    logic         spec_next;
    plc_pkg::fp_t spec_val_next;
    logic         swap;
    plc_pkg::fp_t big, small_op;
    logic [10:0]  eb_next, es_next;
    logic [111:0] wide;
    logic [55:0]  al_next;
    logic [56:0]  s_next;
    logic [55:0]  t_next;
    logic [11:0]  e4_next;
    logic [5:0]   lz, sh_next;
    logic [10:0]  emax;
    logic         zero_next;
    logic [55:0]  t2;
    logic [11:0]  e2;
    plc_pkg::fp_t y_next;
    logic         inc;
    logic [62:0]  mag;

    always_comb begin
        spec_next = 1'b1;
        if (plc_pkg::fp_is_nan(a_in)) begin
            spec_val_next = a_in | plc_pkg::FP_QUIET_BIT;
        end else if (plc_pkg::fp_is_nan(b_in)) begin
            spec_val_next = b_in | plc_pkg::FP_QUIET_BIT;
        end else if (plc_pkg::fp_is_inf(a_in) && plc_pkg::fp_is_inf(b_in) &&
                     (a_in[63] != b_in[63])) begin
            spec_val_next = plc_pkg::FP_DEFAULT_NAN;
        end else if (plc_pkg::fp_is_inf(a_in)) begin
            spec_val_next = a_in;
        end else if (plc_pkg::fp_is_inf(b_in)) begin
            spec_val_next = b_in;
        end else begin
            spec_next     = 1'b0;
            spec_val_next = '0;
        end
        swap     = b_in[62:0] > a_in[62:0];
        big      = swap ? b_in : a_in;
        small_op = swap ? a_in : b_in;
        eb_next  = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        es_next  = (small_op[62:52] == 11'd0) ? 11'd1 : small_op[62:52];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sb_reg       <= big[63];
            s1_ss_reg       <= small_op[63];
            s1_spec_reg     <= spec_next;
            s1_spec_val_reg <= spec_val_next;
            s1_mb_reg       <= {big[62:52] != 11'd0, big[51:0]};
            s1_ms_reg       <= {small_op[62:52] != 11'd0, small_op[51:0]};
            s1_e_reg        <= eb_next;
            s1_d_reg        <= eb_next - es_next;
        end
    end

    always_comb begin
        wide = {s1_ms_reg, 3'd0, 56'd0} >> s1_d_reg[5:0];
        if (s1_d_reg >= 11'd57) begin
            al_next = {55'd0, s1_ms_reg != 53'd0};
        end else begin
            al_next = {wide[111:57], wide[56] | (|wide[55:0])};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_sb_reg       <= s1_sb_reg;
            s2_ss_reg       <= s1_ss_reg;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
            s2_mb_reg       <= s1_mb_reg;
            s2_al_reg       <= al_next;
            s2_e_reg        <= s1_e_reg;
        end
    end

    assign s_next = (s2_sb_reg != s2_ss_reg) ?
                    ({1'b0, s2_mb_reg, 3'd0} - {1'b0, s2_al_reg}) :
                    ({1'b0, s2_mb_reg, 3'd0} + {1'b0, s2_al_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_sb_reg       <= s2_sb_reg;
            s3_zsign_reg    <= s2_sb_reg & s2_ss_reg;
            s3_spec_reg     <= s2_spec_reg;
            s3_spec_val_reg <= s2_spec_val_reg;
            s3_s_reg        <= s_next;
            s3_e_reg        <= s2_e_reg;
        end
    end

    always_comb begin
        lz        = 6'd55 - plc_pkg::msb_pos({8'd0, s3_s_reg[55:0]});
        emax      = s3_e_reg - 11'd1;
        zero_next = 1'b0;
        if (s3_s_reg[56]) begin
            t_next  = {s3_s_reg[56:2], s3_s_reg[1] | s3_s_reg[0]};
            e4_next = {1'b0, s3_e_reg} + 12'd1;
            sh_next = 6'd0;
        end else begin
            t_next    = s3_s_reg[55:0];
            e4_next   = {1'b0, s3_e_reg};
            zero_next = (s3_s_reg[55:0] == 56'd0);
            sh_next   = (emax < {5'd0, lz}) ? emax[5:0] : lz;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_sb_reg       <= s3_sb_reg;
            s4_zsign_reg    <= s3_zsign_reg;
            s4_spec_reg     <= s3_spec_reg;
            s4_spec_val_reg <= s3_spec_val_reg;
            s4_zero_reg     <= zero_next;
            s4_t_reg        <= t_next;
            s4_e_reg        <= e4_next;
            s4_sh_reg       <= sh_next;
        end
    end

    always_comb begin
        t2 = s4_t_reg << s4_sh_reg;
        e2 = s4_e_reg - {6'd0, s4_sh_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_sb_reg       <= s4_sb_reg;
            s5_zsign_reg    <= s4_zsign_reg;
            s5_spec_reg     <= s4_spec_reg;
            s5_spec_val_reg <= s4_spec_val_reg;
            s5_zero_reg     <= s4_zero_reg;
            s5_ovf_reg      <= e2 >= 12'd2047;
            s5_sig_reg      <= t2[55:3];
            s5_g_reg        <= t2[2];
            s5_st_reg       <= t2[1] | t2[0];
            s5_efield_reg   <= t2[55] ? e2[10:0] : 11'd0;
        end
    end

    always_comb begin
        inc = s5_g_reg & (s5_st_reg | s5_sig_reg[0]);
        mag = {s5_efield_reg, s5_sig_reg[51:0]} + 63'(inc);
        if (s5_spec_reg) begin
            y_next = s5_spec_val_reg;
        end else if (s5_zero_reg) begin
            y_next = {s5_zsign_reg, 63'd0};
        end else if (s5_ovf_reg) begin
            y_next = {s5_sb_reg, plc_pkg::FP_EXP_ALL_ONES, 52'd0};
        end else begin
            y_next = {s5_sb_reg, mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;

endmodule

// ===== hw/rtl/plc_front.sv =====
// Input stage that accepts stream words, sorts them into loads and site computations, and feeds the queue.
module plc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index, entry_value, first_vec_0..3, second_vec_0..3, zero pad
    input  logic [plc_pkg::S_TDATA_W-1:0]   s_tdata,
    // command
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            push,
    output plc_pkg::plc_item_t              push_item,
    input  logic                            q_ready
);

    localparam int VAL_LO = plc_pkg::IDX_W;
    localparam int VA_LO  = plc_pkg::IDX_W + plc_pkg::FP_W;
    localparam int VB_LO  = VA_LO + plc_pkg::NUM_STATES * plc_pkg::FP_W;

    logic               valid_reg;
    plc_pkg::plc_item_t item_reg;
    plc_pkg::plc_item_t item_next;

    always_comb begin
        item_next             = '0;
        item_next.command     = s_tuser;
        if (s_tuser == plc_pkg::CMD_COMPUTE) begin
            for (int k = 0; k < plc_pkg::NUM_STATES; k++) begin
                item_next.vec_a[k] = s_tdata[VA_LO + k * plc_pkg::FP_W +: plc_pkg::FP_W];
                item_next.vec_b[k] = s_tdata[VB_LO + k * plc_pkg::FP_W +: plc_pkg::FP_W];
            end
            item_next.last = s_tlast;
        end else begin
            item_next.entry_index = s_tdata[plc_pkg::IDX_W-1:0];
            item_next.entry_value = s_tdata[VAL_LO +: plc_pkg::FP_W];
        end
    end

    assign s_tready  = !valid_reg || q_ready;
    assign push      = valid_reg;
    assign push_item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (q_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hw/rtl/plc_queue.sv =====
// Small first-in first-out queue of classified words between the input stage and the datapath.
module plc_queue #(
    parameter int DEPTH = plc_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  plc_pkg::plc_item_t push_item,
    output logic               q_ready,
    output logic               q_valid,
    output plc_pkg::plc_item_t q_item,
    input  logic               pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    plc_pkg::plc_item_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign q_ready = count_reg != CNT_W'(DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && q_ready) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && q_ready) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop && q_valid) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if ((push && q_ready) && !(pop && q_valid)) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (!(push && q_ready) && (pop && q_valid)) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && q_ready && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not grow on push");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_ready || !$past(push) || pop || count_reg == CNT_W'(DEPTH)))
        else $error("queue push handshake broken");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");
`endif

endmodule

// ===== hw/rtl/plc_back.sv =====
// Datapath: matrix store, sixteen-lane multiply and per-row add chains per matrix, and the final row products.
module plc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  plc_pkg::plc_item_t            q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // partial_0, partial_1, partial_2, partial_3
    output logic [plc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam int NS       = plc_pkg::NUM_STATES;
    localparam int PIPE_LAT = 2 * plc_pkg::MUL_LAT + 3 * plc_pkg::ADD_LAT;

    plc_pkg::fp_t        mat_reg [plc_pkg::STORE_DEPTH];
    plc_pkg::fp_t        prod [2][NS][NS];
    plc_pkg::fp_t        row_sum [2][NS];
    plc_pkg::fp_t        result [NS];
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] last_reg;
    logic                en;

    assign en       = !m_tvalid || m_tready;
    assign q_pop    = q_valid && en;
    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign m_tlast  = last_reg[PIPE_LAT-1];

    always_ff @(posedge aclk) begin
        if (q_pop && (q_item.command == plc_pkg::CMD_LOAD)) begin
            mat_reg[q_item.entry_index] <= q_item.entry_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], q_pop && (q_item.command == plc_pkg::CMD_COMPUTE)};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg <= {last_reg[PIPE_LAT-2:0], q_item.last};
        end
    end

    for (genvar m = 0; m < 2; m++) begin : g_mat
        for (genvar i = 0; i < NS; i++) begin : g_row
            plc_pkg::fp_t first_term, sum1, sum2;
            plc_pkg::fp_t dly2_reg [plc_pkg::ADD_LAT];
            plc_pkg::fp_t dly3_reg [2 * plc_pkg::ADD_LAT];

            for (genvar j = 0; j < NS; j++) begin : g_col
                plc_fp_mul u_mul (
                    .aclk  (aclk),
                    .en    (en),
                    .a_in  ((m == 0) ? q_item.vec_a[j] : q_item.vec_b[j]),
                    .b_in  (mat_reg[m * plc_pkg::MAT_ENTRIES + i * NS + j]),
                    .y_out (prod[m][i][j])
                );
            end

            // Adding the first product to +0.0 only turns a negative zero positive.
            assign first_term = (prod[m][i][0] == plc_pkg::FP_NEG_ZERO) ? '0 : prod[m][i][0];

            always_ff @(posedge aclk) begin
                if (en) begin
                    dly2_reg[0] <= prod[m][i][2];
                    for (int k = 1; k < plc_pkg::ADD_LAT; k++) begin
                        dly2_reg[k] <= dly2_reg[k-1];
                    end
                    dly3_reg[0] <= prod[m][i][3];
                    for (int k = 1; k < 2 * plc_pkg::ADD_LAT; k++) begin
                        dly3_reg[k] <= dly3_reg[k-1];
                    end
                end
            end

            plc_fp_add u_add0 (
                .aclk (aclk), .en (en), .a_in (first_term), .b_in (prod[m][i][1]),
                .y_out (sum1)
            );
            plc_fp_add u_add1 (
                .aclk (aclk), .en (en), .a_in (sum1), .b_in (dly2_reg[plc_pkg::ADD_LAT-1]),
                .y_out (sum2)
            );
            plc_fp_add u_add2 (
                .aclk (aclk), .en (en), .a_in (sum2),
                .b_in (dly3_reg[2 * plc_pkg::ADD_LAT - 1]), .y_out (row_sum[m][i])
            );
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_out
        plc_fp_mul u_comb (
            .aclk  (aclk),
            .en    (en),
            .a_in  (row_sum[0][i]),
            .b_in  (row_sum[1][i]),
            .y_out (result[i])
        );
        assign m_tdata[i * plc_pkg::FP_W +: plc_pkg::FP_W] = result[i];
    end

`ifndef ASSERT_OFF
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("queue popped while the result word is stalled");
`endif

endmodule

// ===== dv/partial_likelihood_combine_unit_tb.sv =====
// Self-checking testbench for the partial likelihood combine unit.
module partial_likelihood_combine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam plc_pkg::fp_t ONE      = 64'h3FF0_0000_0000_0000;
    localparam plc_pkg::fp_t TWO      = 64'h4000_0000_0000_0000;
    localparam plc_pkg::fp_t THREE    = 64'h4008_0000_0000_0000;
    localparam plc_pkg::fp_t FOUR     = 64'h4010_0000_0000_0000;
    localparam plc_pkg::fp_t HALF     = 64'h3FE0_0000_0000_0000;
    localparam plc_pkg::fp_t POS_ZERO = 64'h0;
    localparam plc_pkg::fp_t POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam plc_pkg::fp_t MAX_FP   = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam plc_pkg::fp_t MIN_SUB  = 64'h0000_0000_0000_0001;
    localparam plc_pkg::fp_t ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int  RANDOM_WORDS = 600;
    localparam int  CYCLE_LIMIT  = 400000;

    typedef logic [plc_pkg::NUM_STATES-1:0][plc_pkg::FP_W-1:0] fp_vec_t;

    typedef struct {
        logic                      command;
        logic [plc_pkg::IDX_W-1:0] entry_index;
        plc_pkg::fp_t              entry_value;
        fp_vec_t                   vec_a;
        fp_vec_t                   vec_b;
        logic                      last;
        logic                      typed;
        fp_vec_t                   typed_partials;
    } stim_row_t;

    typedef struct {
        fp_vec_t partials;
        logic    last;
    } site_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [plc_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [plc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tlast;

    plc_pkg::fp_t matrix_copy [plc_pkg::STORE_DEPTH];
    site_result_t expected_sites [$];
    stim_row_t    directed_rows [$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    partial_likelihood_combine_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    function automatic logic same_fp(input plc_pkg::fp_t got, input plc_pkg::fp_t want);
        return (got == want) || (plc_pkg::fp_is_nan(got) && plc_pkg::fp_is_nan(want));
    endfunction

    // Row i of the selected matrix times v, one rounding per product and per sum.
    function automatic real row_sum(input int mat, input int row, input fp_vec_t v);
        real acc;
        real prod;
        acc = 0.0;
        for (int j = 0; j < plc_pkg::NUM_STATES; j++) begin
            prod = $bitstoreal(v[j]) *
                   $bitstoreal(matrix_copy[mat * plc_pkg::MAT_ENTRIES +
                                           row * plc_pkg::NUM_STATES + j]);
            acc = acc + prod;
        end
        return acc;
    endfunction

    function automatic fp_vec_t predict_partials(input fp_vec_t a, input fp_vec_t b);
        fp_vec_t res;
        real s0;
        real s1;
        real r;
        for (int i = 0; i < plc_pkg::NUM_STATES; i++) begin
            s0 = row_sum(0, i, a);
            s1 = row_sum(1, i, b);
            r = s0 * s1;
            res[i] = $realtobits(r);
        end
        return res;
    endfunction

    function automatic plc_pkg::fp_t random_fp();
        plc_pkg::fp_t specials [8] = '{POS_ZERO, plc_pkg::FP_NEG_ZERO, POS_INF,
                                       {1'b1, POS_INF[62:0]}, plc_pkg::FP_DEFAULT_NAN,
                                       MIN_SUB, MAX_FP, 64'h0010_0000_0000_0000};
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return specials[$urandom_range(7)];
            default: return {1'b0, 11'(1023 - $urandom_range(30)), 20'($urandom), $urandom};
        endcase
    endfunction

    function automatic fp_vec_t random_vec();
        fp_vec_t v;
        for (int i = 0; i < plc_pkg::NUM_STATES; i++) begin
            v[i] = random_fp();
        end
        return v;
    endfunction

    function automatic stim_row_t load_row(input logic [plc_pkg::IDX_W-1:0] idx,
                                           input plc_pkg::fp_t val);
        stim_row_t r;
        r = '{plc_pkg::CMD_LOAD, idx, val, random_vec(), random_vec(), 1'($urandom), 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t site_row(input fp_vec_t a, input fp_vec_t b, input logic last,
                                           input logic typed, input fp_vec_t want);
        stim_row_t r;
        r = '{plc_pkg::CMD_COMPUTE, 5'($urandom), {$urandom, $urandom}, a, b, last, typed, want};
        return r;
    endfunction

    // Drives one word and returns after the edge at which it was taken.
    task automatic send_word(input stim_row_t r);
        site_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.command;
        s_tlast  <= r.last;
        s_tdata  <= {3'b000, r.vec_b, r.vec_a, r.entry_value, r.entry_index};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        if (r.command == plc_pkg::CMD_LOAD) begin
            matrix_copy[r.entry_index] = r.entry_value;
        end else begin
            res.partials = r.typed ? r.typed_partials : predict_partials(r.vec_a, r.vec_b);
            res.last = r.last;
            expected_sites = {expected_sites, res};
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_sites.size() == 0) begin
                report_mismatch("result word with no site outstanding");
            end else begin
                for (int i = 0; i < plc_pkg::NUM_STATES; i++) begin
                    if (!same_fp(m_tdata[i*plc_pkg::FP_W +: plc_pkg::FP_W],
                                 expected_sites[0].partials[i])) begin
                        report_mismatch($sformatf("partial_%0d got %h want %h", i,
                            m_tdata[i*plc_pkg::FP_W +: plc_pkg::FP_W],
                            expected_sites[0].partials[i]));
                    end
                end
                if (m_tlast !== expected_sites[0].last) begin
                    report_mismatch($sformatf("result_is_last got %b want %b",
                        m_tlast, expected_sites[0].last));
                end
                void'(expected_sites.pop_front());
            end
        end
    end

    initial begin
        stim_row_t r;
        int phase;
        int drain;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Both matrices start as the identity so that the first sites read off directly.
        for (int k = 0; k < plc_pkg::STORE_DEPTH; k++) begin
            send_word(load_row(5'(k), ((k % plc_pkg::MAT_ENTRIES) % 5 == 0) ? ONE : POS_ZERO));
        end

        directed_rows = {directed_rows, site_row({FOUR, THREE, TWO, ONE}, {4{ONE}}, 1'b0,
                                                 1'b1, {FOUR, THREE, TWO, ONE})};
        directed_rows = {directed_rows, site_row({4{ONE}}, {4{HALF}}, 1'b1, 1'b1, {4{HALF}})};
        directed_rows = {directed_rows, site_row({4{POS_ZERO}}, {4{ONE}}, 1'b1, 1'b1,
                                                 {4{POS_ZERO}})};
        directed_rows = {directed_rows, site_row({4{plc_pkg::FP_NEG_ZERO}},
                                                 {4{plc_pkg::FP_NEG_ZERO}}, 1'b0, 1'b0, '0)};
        directed_rows = {directed_rows, site_row({MAX_FP, MIN_SUB, POS_INF,
                                                  plc_pkg::FP_DEFAULT_NAN},
                                                 {TWO, HALF, POS_ZERO, ONE}, 1'b0, 1'b0, '0)};
        directed_rows = {directed_rows, site_row({ALL_ONES, MAX_FP, MIN_SUB, {1'b1, ONE[62:0]}},
                                                 {4{ALL_ONES}}, 1'b1, 1'b0, '0)};
        directed_rows = {directed_rows, load_row(5'd31, ALL_ONES)};
        directed_rows = {directed_rows, site_row({4{ONE}}, {4{TWO}}, 1'b0, 1'b0, '0)};
        directed_rows = {directed_rows, load_row(5'd31, ONE)};
        directed_rows = {directed_rows, load_row(5'd0, POS_ZERO)};
        directed_rows = {directed_rows, load_row(5'd1, TWO)};
        directed_rows = {directed_rows, load_row(5'd16, MAX_FP)};
        directed_rows = {directed_rows, site_row({FOUR, THREE, TWO, ONE},
                                                 {ONE, ONE, ONE, MAX_FP}, 1'b0, 1'b0, '0)};
        directed_rows = {directed_rows, load_row(5'd17, {1'b1, ONE[62:0]})};
        directed_rows = {directed_rows, site_row({ONE, ONE, HALF, {1'b1, HALF[62:0]}},
                                                 {4{THREE}}, 1'b1, 1'b0, '0)};
        directed_rows = {directed_rows, load_row(5'd5, MIN_SUB)};
        directed_rows = {directed_rows, site_row({4{MIN_SUB}}, {4{HALF}}, 1'b0, 1'b0, '0)};
        foreach (directed_rows[k]) begin
            send_word(directed_rows[k]);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            phase = (n * 5) / RANDOM_WORDS;
            send_idle_pct  = (phase == 1 || phase == 4) ? 60 : (phase == 3 ? 20 : 0);
            recv_stall_pct = (phase == 2 || phase == 4) ? 60 : (phase == 3 ? 20 : 0);
            if ($urandom_range(99) < 30) begin
                r = load_row(5'($urandom), random_fp());
            end else begin
                r = site_row(random_vec(), random_vec(), 1'($urandom), 1'b0, '0);
            end
            send_word(r);
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (expected_sites.size() != 0) begin
            @(posedge aclk);
        end
        while (drain < 40) begin
            @(posedge aclk);
            drain++;
        end
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
